@@ design/sfcsm_pkg.sv @@
// Package for the sensor frame check and slot match block.
// Types, codes and constants shared by the controller, the datapath and the top level.
// No dependencies.
`timescale 1ns / 1ps

package sfcsm_pkg;

	localparam int SLOTS      = 8;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int KIND_SLOTS = 8;   // slots that have a kind field in slot_kinds
	localparam int KINDS_W    = 16;
	localparam int COUNT_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_SLOT_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_KINDS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT = 2'd1;

	// header byte pairs
	localparam logic [7:0] HDR_SHORT_0  = 8'hEA;
	localparam logic [7:0] HDR_SHORT_1  = 8'h4C;
	localparam logic [7:0] HDR_LONGA_0  = 8'h1A;
	localparam logic [7:0] HDR_LONGA_1  = 8'h2D;
	localparam logic [7:0] HDR_LONGB_0  = 8'hFA;
	localparam logic [7:0] HDR_LONGB_1  = 8'h28;
	localparam logic [7:0] SUM_OFFSET   = 8'h0A;

	typedef enum logic [1:0] {
		KIND_SHORT  = 2'd0,
		KIND_LONG_A = 2'd1,
		KIND_LONG_B = 2'd2,
		KIND_OTHER  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STAT_MATCH = 2'd0,
		STAT_CLAIM = 2'd1,
		STAT_BAD   = 2'd2,
		STAT_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FSM_IDLE  = 2'd0,
		FSM_CHECK = 2'd1,
		FSM_MATCH = 2'd2,
		FSM_DONE  = 2'd3
	} fsm_t;

	typedef struct packed {
		logic load;    // capture the input beat
		logic check;   // decode header, run checksum
		logic match;   // slot search, update, result register
	} dp_cmd_t;

	function automatic logic [5:0] nib_add(input logic [7:0] b);
		return 6'(b[7:4]) + 6'(b[3:0]);
	endfunction

endpackage

@@ design/sfcsm_ctrl.sv @@
// Controller FSM for the sensor frame check and slot match block.
// Sequences load, check and match steps in the datapath. Depends on sfcsm_pkg.
`timescale 1ns / 1ps

module sfcsm_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	output logic              out_valid,
	input  logic              out_stall,
	output sfcsm_pkg::dp_cmd_t cmd
);

	sfcsm_pkg::fsm_t state_q, state_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sfcsm_pkg::FSM_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		case (state_q)
			sfcsm_pkg::FSM_IDLE: begin
				if (in_valid) state_next = sfcsm_pkg::FSM_CHECK;
			end
			sfcsm_pkg::FSM_CHECK: state_next = sfcsm_pkg::FSM_MATCH;
			sfcsm_pkg::FSM_MATCH: state_next = sfcsm_pkg::FSM_DONE;
			sfcsm_pkg::FSM_DONE: begin
				if (!out_stall) state_next = sfcsm_pkg::FSM_IDLE;
			end
			default: state_next = sfcsm_pkg::FSM_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = 1'b1;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			sfcsm_pkg::FSM_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			sfcsm_pkg::FSM_CHECK: cmd.check = 1'b1;
			sfcsm_pkg::FSM_MATCH: cmd.match = 1'b1;
			sfcsm_pkg::FSM_DONE:  out_valid = 1'b1;
			default: in_stall = 1'b1;
		endcase
	end

	a_accept_to_check: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == sfcsm_pkg::FSM_CHECK)
		else $error("accepted beat did not start the check step");

	a_check_to_match: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.check |=> cmd.match)
		else $error("match step did not follow check step");

	a_match_to_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match |=> out_valid && in_stall)
		else $error("result not presented after match step");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.check, cmd.match, out_valid}))
		else $error("overlapping datapath commands");

endmodule

@@ design/sfcsm_dp.sv @@
// Datapath for the sensor frame check and slot match block.
// Frame capture, checksum, config registers, slot table and result registers.
// Depends on sfcsm_pkg.
`timescale 1ns / 1ps

module sfcsm_dp (
	input  logic                                clk,
	input  logic                                arst_n,
	input  sfcsm_pkg::dp_cmd_t                  cmd,
	input  logic                                cfg_we,
	input  logic [sfcsm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sfcsm_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic [7:0]                          byte_0,
	input  logic [7:0]                          byte_1,
	input  logic [7:0]                          byte_2,
	input  logic [7:0]                          byte_3,
	input  logic [7:0]                          byte_4,
	input  logic [7:0]                          byte_5,
	input  logic [7:0]                          byte_6,
	input  logic [7:0]                          byte_7,
	input  logic [7:0]                          byte_8,
	output logic [1:0]                          status,
	output logic [sfcsm_pkg::OUT_SLOT_W-1:0]    slot_index,
	output logic [1:0]                          sensor_kind
);

	localparam int SLOTS  = sfcsm_pkg::SLOTS;
	localparam int SLOT_W = sfcsm_pkg::SLOT_W;
	localparam int CNT_W  = sfcsm_pkg::COUNT_W;
	localparam int CMP_W  = (CNT_W > SLOT_W ? CNT_W : SLOT_W) + 1;

	// captured frame
	logic [7:0] b_q [9];

	// config
	logic [sfcsm_pkg::KINDS_W-1:0] kinds_q;
	logic [CNT_W-1:0]              count_q;

	// slot table
	logic             claimed_q [SLOTS];
	logic [7:0]       sid_q     [SLOTS];

	// check results and output registers
	sfcsm_pkg::kind_t   kind_q;
	logic               ok_q;
	sfcsm_pkg::status_t status_q;
	logic [SLOT_W-1:0]  slot_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			b_q[0] <= byte_0;
			b_q[1] <= byte_1;
			b_q[2] <= byte_2;
			b_q[3] <= byte_3;
			b_q[4] <= byte_4;
			b_q[5] <= byte_5;
			b_q[6] <= byte_6;
			b_q[7] <= byte_7;
			b_q[8] <= byte_8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kinds_q <= '0;
			count_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == sfcsm_pkg::CFG_SLOT_KINDS) kinds_q <= cfg_data;
			if (cfg_index == sfcsm_pkg::CFG_SLOT_COUNT) count_q <= cfg_data[CNT_W-1:0];
		end
	end

	// header decode and nibble sums
	sfcsm_pkg::kind_t kind_c;
	logic [7:0]       sum6, sum_short, sum_long, chk_short;
	logic             ok_c;

	always_comb begin
		if (b_q[0] == sfcsm_pkg::HDR_SHORT_0 && b_q[1] == sfcsm_pkg::HDR_SHORT_1)
			kind_c = sfcsm_pkg::KIND_SHORT;
		else if (b_q[0] == sfcsm_pkg::HDR_LONGA_0 && b_q[1] == sfcsm_pkg::HDR_LONGA_1)
			kind_c = sfcsm_pkg::KIND_LONG_A;
		else if (b_q[0] == sfcsm_pkg::HDR_LONGB_0 && b_q[1] == sfcsm_pkg::HDR_LONGB_1)
			kind_c = sfcsm_pkg::KIND_LONG_B;
		else
			kind_c = sfcsm_pkg::KIND_OTHER;

		sum6 = ((8'(sfcsm_pkg::nib_add(b_q[0])) + 8'(sfcsm_pkg::nib_add(b_q[1])))
			+ (8'(sfcsm_pkg::nib_add(b_q[2])) + 8'(sfcsm_pkg::nib_add(b_q[3]))))
			+ (8'(sfcsm_pkg::nib_add(b_q[4])) + 8'(sfcsm_pkg::nib_add(b_q[5])));
		sum_short = sum6 + 8'(b_q[6][3:0]) - sfcsm_pkg::SUM_OFFSET;
		sum_long  = sum6 + (8'(sfcsm_pkg::nib_add(b_q[6])) + 8'(sfcsm_pkg::nib_add(b_q[7])))
			- sfcsm_pkg::SUM_OFFSET;
		chk_short = {b_q[7][3:0], b_q[6][7:4]};

		case (kind_c)
			sfcsm_pkg::KIND_SHORT:  ok_c = (sum_short == chk_short);
			sfcsm_pkg::KIND_LONG_A,
			sfcsm_pkg::KIND_LONG_B: ok_c = (sum_long == b_q[8]);
			default:                ok_c = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= sfcsm_pkg::KIND_SHORT;
			ok_q   <= 1'b0;
		end else if (cmd.check) begin
			kind_q <= kind_c;
			ok_q   <= ok_c;
		end
	end

	// slot search: per-slot compare, then first-set priority pick
	logic [SLOTS-1:0]  hit_v, free_v;
	logic              hit_any, free_any;
	logic [SLOT_W-1:0] hit_idx, free_idx;

	always_comb begin
		logic [1:0] sk;
		logic       en;
		for (int i = 0; i < SLOTS; i++) begin
			sk = 2'(sfcsm_pkg::KIND_OTHER);
			if (i < sfcsm_pkg::KIND_SLOTS) sk = kinds_q[(2*i) % sfcsm_pkg::KINDS_W +: 2];
			en = (CMP_W'(i) < CMP_W'(count_q)) && (sk == 2'(kind_q));
			hit_v[i]  = en && (sid_q[i] == b_q[3]);
			free_v[i] = en && !claimed_q[i];
		end
		hit_any  = |hit_v;
		free_any = |free_v;
		hit_idx  = '0;
		free_idx = '0;
		for (int i = SLOTS - 1; i >= 0; i--) begin
			if (hit_v[i])  hit_idx  = SLOT_W'(i);
			if (free_v[i]) free_idx = SLOT_W'(i);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOTS; i++) begin
				claimed_q[i] <= 1'b0;
				sid_q[i]     <= '0;
			end
			status_q <= sfcsm_pkg::STAT_BAD;
			slot_q   <= '0;
		end else if (cmd.match) begin
			if (!ok_q) begin
				status_q <= sfcsm_pkg::STAT_BAD;
				slot_q   <= '0;
			end else if (hit_any) begin
				status_q <= sfcsm_pkg::STAT_MATCH;
				slot_q   <= hit_idx;
			end else if (free_any) begin
				status_q           <= sfcsm_pkg::STAT_CLAIM;
				slot_q             <= free_idx;
				claimed_q[free_idx] <= 1'b1;
				sid_q[free_idx]     <= b_q[3];
			end else begin
				status_q <= sfcsm_pkg::STAT_FULL;
				slot_q   <= '0;
			end
		end
	end

	assign status      = status_q;
	assign slot_index  = sfcsm_pkg::OUT_SLOT_W'(slot_q);
	assign sensor_kind = kind_q;

	a_bad_slot_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(status_q == sfcsm_pkg::STAT_BAD || status_q == sfcsm_pkg::STAT_FULL) |-> slot_q == '0)
		else $error("slot index nonzero on failed frame");

	a_claim_sets_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match && ok_q && !hit_any && free_any |=> claimed_q[slot_q])
		else $error("claimed slot not marked");

	a_bad_when_not_ok: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.match && !ok_q |=> status_q == sfcsm_pkg::STAT_BAD)
		else $error("failed checksum not reported");

endmodule

@@ design/sensor_frame_check_and_slot_match_core.sv @@
// Top level of the sensor frame check and slot match block.
// The FSM walks load, check, match and result steps, one frame at a time; out_valid rises
// in the result step, after the check and match steps, and a new frame is accepted only
// once the result beat has left, which waits while the output is stalled.
// Reset (arst_n, async, low): FSM idle, config registers zero, all slots unclaimed, ids zero.
`timescale 1ns / 1ps

module sensor_frame_check_and_slot_match_core (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_we,
	input  logic [sfcsm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfcsm_pkg::CFG_DATA_W-1:0] cfg_data,
	// input frame beat
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [7:0]                       byte_0,
	input  logic [7:0]                       byte_1,
	input  logic [7:0]                       byte_2,
	input  logic [7:0]                       byte_3,
	input  logic [7:0]                       byte_4,
	input  logic [7:0]                       byte_5,
	input  logic [7:0]                       byte_6,
	input  logic [7:0]                       byte_7,
	input  logic [7:0]                       byte_8,
	// result beat
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic [sfcsm_pkg::OUT_SLOT_W-1:0] slot_index,
	output logic [1:0]                       sensor_kind
);

	// Controller issues at most one step command per cycle; datapath holds all frame,
	// config and slot state. Result registers sit in the datapath and stay put
	// while out_valid is high and stalled.
	sfcsm_pkg::dp_cmd_t cmd;

	sfcsm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Checksum: 13-nibble (short) or 16-nibble (long) sum tree minus 10, compared
	// with the split check nibbles (short kind) or byte 8 (long kinds). Slot search:
	// parallel kind/id compare over all slots, first match wins, else first unclaimed
	// slot. Stored ids reset to zero, so id zero matches an unclaimed slot.
	sfcsm_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.byte_0      (byte_0),
		.byte_1      (byte_1),
		.byte_2      (byte_2),
		.byte_3      (byte_3),
		.byte_4      (byte_4),
		.byte_5      (byte_5),
		.byte_6      (byte_6),
		.byte_7      (byte_7),
		.byte_8      (byte_8),
		.status      (status),
		.slot_index  (slot_index),
		.sensor_kind (sensor_kind)
	);

endmodule

@@ bench/sensor_frame_check_and_slot_match_core_tb.sv @@
// Self-checking bench for sensor_frame_check_and_slot_match_core: header decode, nibble-sum
// check and slot match/claim, predicted per accepted frame and compared on every result beat.
// Depends on design/sfcsm_pkg.sv and the core RTL only.
`timescale 1ns / 1ps

module sensor_frame_check_and_slot_match_core_tb;

	localparam int IDLE_LIMIT = 2000;   // cycles with no beat on either side before giving up
	localparam int BREAK_PCT  = 18;     // chance per cycle that a side idles or stalls
	localparam int CALM_FROM  = 3000;   // cycle window where neither side idles or stalls at random
	localparam int CALM_TO    = 5000;
	localparam int MAX_LINES  = 100;    // keep the log bounded if things go badly wrong
	localparam int PHASE_ITEMS = 200;

	// unused register slots of the write port; a write there must change nothing
	localparam logic [sfcsm_pkg::CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
	localparam logic [sfcsm_pkg::CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

	typedef logic [8:0][7:0] frame_t;   // frame[i] is radio byte i

	typedef struct packed {
		sfcsm_pkg::status_t                status;
		logic [sfcsm_pkg::OUT_SLOT_W-1:0]  slot;
		sfcsm_pkg::kind_t                  kind;
	} verdict_t;

	// ---------------------------------------------------------------- DUT hookup
	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_we = 1'b0;
	logic [sfcsm_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [sfcsm_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	frame_t                           cur_frame = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [1:0]                       status;
	logic [sfcsm_pkg::OUT_SLOT_W-1:0] slot_index;
	logic [1:0]                       sensor_kind;

	sensor_frame_check_and_slot_match_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.byte_0      (cur_frame[0]),
		.byte_1      (cur_frame[1]),
		.byte_2      (cur_frame[2]),
		.byte_3      (cur_frame[3]),
		.byte_4      (cur_frame[4]),
		.byte_5      (cur_frame[5]),
		.byte_6      (cur_frame[6]),
		.byte_7      (cur_frame[7]),
		.byte_8      (cur_frame[8]),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.slot_index  (slot_index),
		.sensor_kind (sensor_kind)
	);

	always #5 clk = ~clk;

	// ---------------------------------------------------------------- bench state
	frame_t   frame_q[$];      // frames waiting to be driven
	verdict_t verdict_q[$];    // predicted results, oldest first
	int       err_count = 0;
	int       cyc = 0;
	int       stuck = 0;
	bit       in_taken = 1'b0; // set at the edge that accepts a frame, cleared by the driver

	// shadow of the block: register copies and the slot table
	logic [sfcsm_pkg::KINDS_W-1:0]  kinds_reg = '0;
	logic [sfcsm_pkg::COUNT_W-1:0]  count_reg = '0;
	logic                           slot_taken [sfcsm_pkg::SLOTS];
	logic [7:0]                     slot_id [sfcsm_pkg::SLOTS];

	initial begin
		for (int i = 0; i < sfcsm_pkg::SLOTS; i++) begin
			slot_taken[i] = 1'b0;
			slot_id[i] = 8'h00;
		end
	end

	task automatic note_error(input string msg);
		err_count++;
		if (err_count <= MAX_LINES)
			$display("ERROR @%0t: %s", $time, msg);
	endtask

	function automatic bit take_break();
		if (cyc >= CALM_FROM && cyc < CALM_TO)
			return 1'b0;
		return $urandom_range(99) < BREAK_PCT;
	endfunction

	// Sum of both nibbles of bytes 0..n-1.
	function automatic int nibble_total(input frame_t f, input int n);
		int s;
		s = 0;
		for (int i = 0; i < n; i++)
			s += int'(f[i][7:4]) + int'(f[i][3:0]);
		return s;
	endfunction

	// Predict the result of one accepted frame and update the slot table.
	function automatic verdict_t frame_verdict(input frame_t f);
		verdict_t         r;
		sfcsm_pkg::kind_t k;
		logic             ok;
		logic             hit;
		int               lim;
		logic [7:0]       want;
		r.status = sfcsm_pkg::STAT_BAD;
		r.slot = '0;
		ok = 1'b0;
		hit = 1'b0;
		if (f[0] == sfcsm_pkg::HDR_SHORT_0 && f[1] == sfcsm_pkg::HDR_SHORT_1)
			k = sfcsm_pkg::KIND_SHORT;
		else if (f[0] == sfcsm_pkg::HDR_LONGA_0 && f[1] == sfcsm_pkg::HDR_LONGA_1)
			k = sfcsm_pkg::KIND_LONG_A;
		else if (f[0] == sfcsm_pkg::HDR_LONGB_0 && f[1] == sfcsm_pkg::HDR_LONGB_1)
			k = sfcsm_pkg::KIND_LONG_B;
		else
			k = sfcsm_pkg::KIND_OTHER;
		r.kind = k;

		// short check: nibbles of bytes 0..5 plus low nibble of byte 6, compared with the
		// split check nibbles; long check: all nibbles of bytes 0..7 against byte 8
		if (k == sfcsm_pkg::KIND_SHORT) begin
			want = 8'(nibble_total(f, 6) + int'(f[6][3:0]) - int'(sfcsm_pkg::SUM_OFFSET));
			ok = (want == {f[7][3:0], f[6][7:4]});
		end else if (k != sfcsm_pkg::KIND_OTHER) begin
			want = 8'(nibble_total(f, 8) - int'(sfcsm_pkg::SUM_OFFSET));
			ok = (want == f[8]);
		end

		if (ok) begin
			lim = (int'(count_reg) > sfcsm_pkg::SLOTS) ? sfcsm_pkg::SLOTS : int'(count_reg);
			// match looks at kind and stored id only, claimed or not (id 0 hits a fresh slot)
			for (int i = 0; i < lim && !hit; i++) begin
				if (i < sfcsm_pkg::KIND_SLOTS
						&& sfcsm_pkg::kind_t'(kinds_reg[2*i +: 2]) == k
						&& slot_id[i] == f[3]) begin
					hit = 1'b1;
					r.status = sfcsm_pkg::STAT_MATCH;
					r.slot = sfcsm_pkg::OUT_SLOT_W'(i);
				end
			end
			for (int i = 0; i < lim && !hit; i++) begin
				if (i < sfcsm_pkg::KIND_SLOTS
						&& sfcsm_pkg::kind_t'(kinds_reg[2*i +: 2]) == k
						&& !slot_taken[i]) begin
					hit = 1'b1;
					slot_taken[i] = 1'b1;
					slot_id[i] = f[3];
					r.status = sfcsm_pkg::STAT_CLAIM;
					r.slot = sfcsm_pkg::OUT_SLOT_W'(i);
				end
			end
			if (!hit)
				r.status = sfcsm_pkg::STAT_FULL;
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- stimulus helpers
	// Random frame of kind k with the given id; good=0 corrupts the check field.
	function automatic frame_t make_frame(input sfcsm_pkg::kind_t k, input logic [7:0] id,
			input bit good);
		frame_t     f;
		logic [7:0] chk;
		for (int i = 0; i < 9; i++)
			f[i] = 8'($urandom);
		case (k)
			sfcsm_pkg::KIND_SHORT: begin
				f[0] = sfcsm_pkg::HDR_SHORT_0;
				f[1] = sfcsm_pkg::HDR_SHORT_1;
			end
			sfcsm_pkg::KIND_LONG_A: begin
				f[0] = sfcsm_pkg::HDR_LONGA_0;
				f[1] = sfcsm_pkg::HDR_LONGA_1;
			end
			sfcsm_pkg::KIND_LONG_B: begin
				f[0] = sfcsm_pkg::HDR_LONGB_0;
				f[1] = sfcsm_pkg::HDR_LONGB_1;
			end
			default: begin
				// all-ones header, a near miss on one byte, or plain noise
				case ($urandom_range(2))
					0: f[1:0] = 16'hFFFF;
					1: f[0] = ($urandom_range(1)) ? sfcsm_pkg::HDR_SHORT_0
						: sfcsm_pkg::HDR_LONGB_0;
					default: ;
				endcase
			end
		endcase
		f[3] = id;
		if (k == sfcsm_pkg::KIND_SHORT) begin
			chk = 8'(nibble_total(f, 6) + int'(f[6][3:0]) - int'(sfcsm_pkg::SUM_OFFSET));
			if (!good)
				chk ^= 8'($urandom_range(1, 255));
			f[6][7:4] = chk[3:0];
			f[7][3:0] = chk[7:4];
		end else if (k == sfcsm_pkg::KIND_LONG_A || k == sfcsm_pkg::KIND_LONG_B) begin
			chk = 8'(nibble_total(f, 8) - int'(sfcsm_pkg::SUM_OFFSET));
			if (!good)
				chk ^= 8'($urandom_range(1, 255));
			f[8] = chk;
		end
		return f;
	endfunction

	// small id pool so that matches are common; 0 and FF are the edge ids
	function automatic logic [7:0] pick_id();
		case ($urandom_range(7))
			0: return 8'h00;
			1: return 8'hFF;
			2: return 8'h5A;
			3: return 8'h33;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic sfcsm_pkg::kind_t checked_kind();
		case ($urandom_range(2))
			0: return sfcsm_pkg::KIND_SHORT;
			1: return sfcsm_pkg::KIND_LONG_A;
			default: return sfcsm_pkg::KIND_LONG_B;
		endcase
	endfunction

	task automatic write_reg(input logic [sfcsm_pkg::CFG_IDX_W-1:0] idx,
			input logic [sfcsm_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == sfcsm_pkg::CFG_SLOT_KINDS)
			kinds_reg = val[sfcsm_pkg::KINDS_W-1:0];
		else if (idx == sfcsm_pkg::CFG_SLOT_COUNT)
			count_reg = val[sfcsm_pkg::COUNT_W-1:0];
	endtask

	// upper data bits of the count write are junk on purpose
	task automatic set_slots(input logic [15:0] kinds, input logic [3:0] count);
		write_reg(sfcsm_pkg::CFG_SLOT_KINDS, kinds);
		write_reg(sfcsm_pkg::CFG_SLOT_COUNT, {12'($urandom), count});
	endtask

	// Block is idle once nothing is queued, in flight or owed.
	task automatic settle();
		while (frame_q.size() != 0 || in_valid || verdict_q.size() != 0)
			@(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic random_phase(input logic [15:0] kinds, input logic [3:0] count, input int n);
		int roll;
		set_slots(kinds, count);
		for (int j = 0; j < n; j++) begin
			roll = $urandom_range(99);
			if (roll < 70)
				frame_q.push_back(make_frame(checked_kind(), pick_id(), 1'b1));
			else if (roll < 85)
				frame_q.push_back(make_frame(checked_kind(), pick_id(), 1'b0));
			else
				frame_q.push_back(make_frame(sfcsm_pkg::KIND_OTHER, 8'($urandom), 1'b1));
		end
		settle();
	endtask

	// ---------------------------------------------------------------- sequence
	initial begin
		frame_t f;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// No slots registered: every good frame finds no slot.
		write_reg(sfcsm_pkg::CFG_SLOT_COUNT, 16'h0000);
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h12, 1'b1));
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_A, 8'h00, 1'b1));
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_B, 8'hFF, 1'b1));
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_OTHER, 8'h00, 1'b1));
		settle();

		// slots 0..7 kinds: short, long A, long B, other, short, long A, long B, long A
		set_slots(16'b01_10_01_00_11_10_01_00, 4'd3);
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h00, 1'b1));  // id 0 hits slot 0
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h55, 1'b1));  // claims slot 0
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h55, 1'b1));  // matches slot 0
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h66, 1'b1));  // no short slot
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_A, 8'hFF, 1'b1)); // claims slot 1
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_B, 8'h00, 1'b1)); // id 0 hits slot 2
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_B, 8'h07, 1'b1)); // claims slot 2
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h55, 1'b0));  // bad short check
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_A, 8'hFF, 1'b0)); // bad long check
		f = make_frame(sfcsm_pkg::KIND_LONG_B, 8'h07, 1'b1);
		f[1:0] = 16'hFFFF;                                       // all-ones header never passes
		frame_q.push_back(f);
		settle();

		// widen to five slots: the kind-3 slot is skipped, the second short slot is taken
		write_reg(sfcsm_pkg::CFG_SLOT_COUNT, 16'h0005);
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h66, 1'b1));
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_OTHER, 8'h00, 1'b1));
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_LONG_A, 8'hFF, 1'b1));
		settle();

		// every slot kind 3 and count beyond the table; spare indexes written too
		set_slots(16'hFFFF, 4'd15);
		write_reg(CFG_SPARE_2, 16'($urandom));
		write_reg(CFG_SPARE_3, 16'hFFFF);
		frame_q.push_back(make_frame(sfcsm_pkg::KIND_SHORT, 8'h55, 1'b1));
		frame_q.push_back(72'h0);
		frame_q.push_back({9{8'hFF}});
		f = make_frame(sfcsm_pkg::KIND_LONG_A, 8'hFF, 1'b1);
		frame_q.push_back(f);
		settle();

		// random part: settings step the count up to 15, then back to 9 and 8, so claims spread over the run
		random_phase(16'($urandom), 4'd2, PHASE_ITEMS);
		random_phase(16'h0000, 4'd4, PHASE_ITEMS);
		random_phase(16'($urandom), 4'd6, PHASE_ITEMS);
		write_reg(CFG_SPARE_3, 16'($urandom));
		random_phase(16'hFFFF, 4'd8, PHASE_ITEMS);
		random_phase(16'($urandom), 4'd8, PHASE_ITEMS);
		random_phase(16'h5555, 4'd15, PHASE_ITEMS);
		write_reg(CFG_SPARE_2, 16'h0000);
		random_phase(16'hAAAA, 4'd9, PHASE_ITEMS);
		random_phase(16'($urandom), 4'd8, PHASE_ITEMS);

		repeat (8) @(posedge clk);
		if (verdict_q.size() != 0)
			note_error($sformatf("%0d results never arrived", verdict_q.size()));
		if (err_count == 0)
			$display("** sensor_frame_check_and_slot_match_core: PASSED **");
		else
			$display("** sensor_frame_check_and_slot_match_core: FAILED **");
		$finish;
	end

	// ---------------------------------------------------------------- input side
	// Accepting edge: predict right away, since slot state moves in frame order.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (arst_n && in_valid && !in_stall) begin
			verdict_q.push_back(frame_verdict(cur_frame));
			in_taken = 1'b1;
		end
	end

	// Driver: a beat holds until taken, then the next frame or an idle cycle.
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_taken)) begin
			in_taken = 1'b0;
			if (frame_q.size() != 0 && !take_break()) begin
				cur_frame <= frame_q.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------- output side
	always @(negedge clk) begin
		if (arst_n)
			out_stall <= take_break();
	end

	always @(posedge clk) begin
		verdict_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				note_error($sformatf("result beat with nothing pending: status %0d slot %0d kind %0d",
					status, slot_index, sensor_kind));
			end else begin
				want = verdict_q.pop_front();
				if (status !== want.status)
					note_error($sformatf("status %0d, expected %0d", status, want.status));
				if (slot_index !== want.slot)
					note_error($sformatf("slot_index %0d, expected %0d", slot_index, want.slot));
				if (sensor_kind !== want.kind)
					note_error($sformatf("sensor_kind %0d, expected %0d", sensor_kind, want.kind));
			end
		end
	end

	// Watchdog: no beat on either side for too long means the block hung.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				stuck <= 0;
			end else if (stuck >= IDLE_LIMIT) begin
				$display("ERROR @%0t: no beat for %0d cycles", $time, IDLE_LIMIT);
				$display("** sensor_frame_check_and_slot_match_core: FAILED **");
				$finish;
			end else begin
				stuck <= stuck + 1;
			end
		end
	end

endmodule

@@ filelist.f @@
design/sfcsm_pkg.sv
design/sfcsm_ctrl.sv
design/sfcsm_dp.sv
design/sensor_frame_check_and_slot_match_core.sv
bench/sensor_frame_check_and_slot_match_core_tb.sv
